### design/wfds_pkg.sv
`default_nettype none
package wfds_pkg;

    localparam int FRAME_SIZE_DEF = 128;
    localparam int PWR_W = 48;
    localparam int LOG_W = 22;
    localparam int DB_W = 48;

    localparam logic [PWR_W-1:0] PWR_MAX = {PWR_W{1'b1}};
    localparam logic [PWR_W-1:0] PWR_ONE = PWR_W'(64'd1 << 20);
    localparam logic signed [22:0] DB_K = 23'sd3156528;
    localparam logic signed [22:0] LOG_OFFSET = 23'sd1310720;
    localparam logic signed [DB_W-1:0] DB_FLOOR = -(48'sd1920 <<< 32);

    typedef struct packed {
        logic ld_we;
        logic rd;
        logic mul;
        logic wr_sum;
        logic wr_diff;
        logic sq;
        logic pk_clr;
        logic pk_acc;
        logic pw_load;
        logic lg_start;
        logic lg_sel_pk;
        logic db_pk;
        logic db_lv;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic lg_done;
        logic out_free;
    } t_stat;

    // Cosine of p/65536 of a turn in Q15, built from Taylor sums in Q30.
    function automatic logic signed [16:0] cosq(input logic [15:0] p);
        logic [1:0] q;
        logic [13:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic signed [63:0] v;
        logic signed [63:0] y;
        q = p[15:14];
        r = p[13:0];
        x = ({50'd0, r} * 64'd3373259426 + 64'd16384) >> 15;
        x2 = (x * x) >> 30;
        c = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) c = c - $signed(term);
            else c = c + $signed(term);
        end
        s = $signed(x);
        term = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s = s - $signed(term);
            else s = s + $signed(term);
        end
        if (c < 0) c = 0;
        if (s < 0) s = 0;
        unique case (q)
            2'd0: v = c;
            2'd1: v = -s;
            2'd2: v = -c;
            default: v = s;
        endcase
        y = (v + 64'sd16384) >>> 15;
        return y[16:0];
    endfunction

endpackage
`default_nettype wire

### design/wfds_log2.sv
`default_nettype none
module wfds_log2 import wfds_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [PWR_W-1:0] i_value,
    output logic                  o_done,
    output logic [LOG_W-1:0]      o_log
);
    localparam logic [4:0] NORM_LAST = 5'd5;
    localparam logic [4:0] STEP_LAST = 5'd21;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [4:0]       r_cnt, n_cnt;
    logic [PWR_W-1:0] r_x, n_x;
    logic [5:0]       r_e, n_e;
    logic [30:0]      r_m, n_m;
    logic [15:0]      r_frac, n_frac;

    logic [5:0]  sh;
    logic [30:0] m_cur;
    logic [61:0] sq_full;
    logic [31:0] sq;

    always_comb begin
        sh = 6'd32 >> r_cnt[2:0];
        m_cur = (r_cnt == NORM_LAST + 5'd1) ? r_x[PWR_W-1:PWR_W-31] : r_m;
        sq_full = {31'd0, m_cur} * {31'd0, m_cur};
        sq = sq_full[61:30];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_x = r_x;
        n_e = r_e;
        n_m = r_m;
        n_frac = r_frac;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_x = i_value;
            n_e = 6'd47;
            n_frac = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 5'd1;
            if (r_cnt <= NORM_LAST) begin
                // Binary search for the leading one, one shift size per cycle.
                if ((r_x >> (6'd48 - sh)) == '0) begin
                    n_x = r_x << sh;
                    n_e = r_e - sh;
                end
            end else begin
                n_frac = {r_frac[14:0], sq[31]};
                n_m = sq[31] ? sq[31:1] : sq[30:0];
                if (r_cnt == STEP_LAST) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_x <= n_x;
        r_e <= n_e;
        r_m <= n_m;
        r_frac <= n_frac;
    end

    assign o_done = r_done;
    assign o_log = {r_e, r_frac};
endmodule
`default_nettype wire

### design/wfds_datapath.sv
`default_nettype none
module wfds_datapath import wfds_pkg::*; #(
    parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cmd                            i_cmd,
    output t_stat                                o_stat,
    input  wire logic [$clog2(FRAME_SIZE)-1:0]   i_addr_a,
    input  wire logic [$clog2(FRAME_SIZE)-1:0]   i_addr_b,
    input  wire logic [$clog2(FRAME_SIZE)-2:0]   i_tw_idx,
    input  wire logic [$clog2(FRAME_SIZE)-2:0]   i_bin,
    input  wire logic                            i_last,
    input  wire logic signed [7:0]               i_sample,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [5:0]                           o_bin_index,
    output logic signed [11:0]                   o_level_db,
    output logic                                 o_last_bin
);
    localparam int LOG2N = $clog2(FRAME_SIZE);
    localparam int IW = LOG2N;
    localparam int HALF_N = FRAME_SIZE / 2;
    localparam int TW_STEP = 65536 / FRAME_SIZE;

    logic signed [16:0] w_win [FRAME_SIZE];
    logic signed [16:0] w_twr [HALF_N];
    logic signed [16:0] w_twi [HALF_N];

    for (genvar g = 0; g < FRAME_SIZE; g++) begin : g_win
        localparam int unsigned PH = (g * 131072 + (FRAME_SIZE - 1)) / (2 * (FRAME_SIZE - 1));
        localparam logic signed [16:0] CV = cosq(PH[15:0]);
        localparam logic signed [33:0] PR = (34'sd15073 * CV + 34'sd16384) >>> 15;
        localparam logic signed [16:0] WV = 17'sd17695 - PR[16:0];
        assign w_win[g] = WV;
    end

    for (genvar g = 0; g < HALF_N; g++) begin : g_tw
        localparam int unsigned TP = g * TW_STEP;
        assign w_twr[g] = cosq(TP[15:0]);
        assign w_twi[g] = cosq(16'(TP + 16384));
    end

    logic [63:0] r_mem [FRAME_SIZE];
    logic [63:0] r_rd_a, r_rd_b;
    logic signed [48:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic [63:0] r_diff;
    logic [63:0] r_sq_re, r_sq_im;
    logic [PWR_W-1:0] r_peak;
    logic [PWR_W-1:0] r_pwr;
    logic signed [DB_W-1:0] r_dpk, r_dlv;
    logic r_out_valid;
    logic [5:0] r_out_bin;
    logic signed [11:0] r_out_lvl;
    logic r_out_last;

    logic [IW-1:0] rev_a;
    logic signed [24:0] win_prod;
    logic signed [19:0] win_x;
    logic signed [31:0] ar, ai, br, bi, tr, ti;
    logic signed [49:0] tr_full, ti_full;
    logic [31:0] mag_re, mag_im;
    logic [64:0] pw_sum;
    logic [PWR_W-1:0] pw_sat;
    logic lg_done;
    logic [LOG_W-1:0] lg_val;
    logic signed [22:0] lg_diff;
    logic signed [DB_W-1:0] db_val;
    logic signed [DB_W:0] lv_full;
    logic signed [DB_W:0] lv_shift;
    logic signed [11:0] lv_clamp;
    logic mem_we;
    logic [IW-1:0] mem_waddr;
    logic [63:0] mem_wdata;

    always_comb begin
        for (int k = 0; k < IW; k++) begin
            rev_a[k] = i_addr_a[IW-1-k];
        end
        win_prod = i_sample * w_win[i_addr_a];
        win_prod = win_prod + 25'sd16;
        win_x = win_prod[24:5];

        ar = r_rd_a[31:0];
        ai = r_rd_a[63:32];
        br = r_rd_b[31:0];
        bi = r_rd_b[63:32];
        tr_full = 50'(r_p_rr) - 50'(r_p_ii) + 50'sd16384;
        ti_full = 50'(r_p_ri) + 50'(r_p_ir) + 50'sd16384;
        tr = tr_full[46:15];
        ti = ti_full[46:15];

        mag_re = ar[31] ? (~ar + 32'd1) : ar;
        mag_im = ai[31] ? (~ai + 32'd1) : ai;
        pw_sum = {1'b0, r_sq_re} + {1'b0, r_sq_im};
        pw_sat = (pw_sum > {17'd0, PWR_MAX}) ? PWR_MAX : pw_sum[PWR_W-1:0];

        lg_diff = $signed({1'b0, lg_val}) - LOG_OFFSET;
        db_val = lg_diff * DB_K;

        lv_full = {r_dlv[DB_W-1], r_dlv} - {r_dpk[DB_W-1], r_dpk} + 49'sd2147483648;
        lv_shift = lv_full >>> 32;
        if (lv_shift > 49'sd2047) lv_clamp = 12'sd2047;
        else if (lv_shift < -49'sd2048) lv_clamp = -12'sd2048;
        else lv_clamp = lv_shift[11:0];

        mem_we = i_cmd.ld_we || i_cmd.wr_sum || i_cmd.wr_diff;
        priority if (i_cmd.ld_we) begin
            mem_waddr = rev_a;
            mem_wdata = {32'd0, 32'(win_x)};
        end else if (i_cmd.wr_sum) begin
            mem_waddr = i_addr_a;
            mem_wdata = {ai + ti, ar + tr};
        end else begin
            mem_waddr = i_addr_b;
            mem_wdata = r_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem[i_addr_a];
            r_rd_b <= r_mem[i_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_rr <= w_twr[i_tw_idx] * br;
            r_p_ii <= w_twi[i_tw_idx] * bi;
            r_p_ri <= w_twr[i_tw_idx] * bi;
            r_p_ir <= w_twi[i_tw_idx] * br;
        end
        if (i_cmd.wr_sum) begin
            r_diff <= {ai - ti, ar - tr};
        end
        if (i_cmd.sq) begin
            r_sq_re <= {32'd0, mag_re} * {32'd0, mag_re};
            r_sq_im <= {32'd0, mag_im} * {32'd0, mag_im};
        end
        if (i_cmd.pw_load) begin
            r_pwr <= (pw_sat < PWR_ONE) ? PWR_ONE : pw_sat;
        end
        if (i_cmd.db_pk) begin
            r_dpk <= (r_peak == '0) ? DB_FLOOR : db_val;
        end
        if (i_cmd.db_lv) begin
            r_dlv <= db_val;
        end
        if (i_cmd.out_load) begin
            r_out_bin <= 6'(i_bin);
            r_out_lvl <= lv_clamp;
            r_out_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pk_clr) begin
                r_peak <= '0;
            end else if (i_cmd.pk_acc && pw_sat > r_peak) begin
                r_peak <= pw_sat;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    wfds_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lg_start),
        .i_value (i_cmd.lg_sel_pk ? r_peak : r_pwr),
        .o_done  (lg_done),
        .o_log   (lg_val)
    );

    assign o_stat.lg_done = lg_done;
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_bin_index = r_out_bin;
    assign o_level_db = r_out_lvl;
    assign o_last_bin = r_out_last;
endmodule
`default_nettype wire

### design/wfds_ctrl.sv
`default_nettype none
module wfds_ctrl import wfds_pkg::*; #(
    parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    output t_cmd                               o_cmd,
    input  wire t_stat                         i_stat,
    output logic [$clog2(FRAME_SIZE)-1:0]      o_addr_a,
    output logic [$clog2(FRAME_SIZE)-1:0]      o_addr_b,
    output logic [$clog2(FRAME_SIZE)-2:0]      o_tw_idx,
    output logic [$clog2(FRAME_SIZE)-2:0]      o_bin,
    output logic                               o_last
);
    localparam int LOG2N = $clog2(FRAME_SIZE);
    localparam int IW = LOG2N;
    localparam int HW = LOG2N - 1;
    localparam int SW = $clog2(LOG2N);
    localparam logic [IW-1:0] CNT_LAST = IW'(FRAME_SIZE - 1);
    localparam logic [HW-1:0] HALF_LAST = HW'(FRAME_SIZE / 2 - 1);
    localparam logic [SW-1:0] STG_LAST = SW'(LOG2N - 1);

    typedef enum logic [17:0] {
        S_LOAD   = 18'b000000000000000001,
        S_BF_RD  = 18'b000000000000000010,
        S_BF_MUL = 18'b000000000000000100,
        S_BF_WA  = 18'b000000000000001000,
        S_BF_WB  = 18'b000000000000010000,
        S_PK_RD  = 18'b000000000000100000,
        S_PK_SQ  = 18'b000000000001000000,
        S_PK_ACC = 18'b000000000010000000,
        S_PK_GO  = 18'b000000000100000000,
        S_PK_LOG = 18'b000000001000000000,
        S_PK_DB  = 18'b000000010000000000,
        S_LV_RD  = 18'b000000100000000000,
        S_LV_SQ  = 18'b000001000000000000,
        S_LV_ACC = 18'b000010000000000000,
        S_LV_GO  = 18'b000100000000000000,
        S_LV_LOG = 18'b001000000000000000,
        S_LV_DB  = 18'b010000000000000000,
        S_LV_OUT = 18'b100000000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_stage, n_stage;
    logic [HW-1:0] r_bcnt, n_bcnt;

    logic [IW-1:0] half, hmask, bext, kk, addr_a, tw_full;
    logic [SW-1:0] tw_sh;

    always_comb begin
        half = IW'(1) << r_stage;
        hmask = half - IW'(1);
        bext = {1'b0, r_bcnt};
        kk = bext & hmask;
        addr_a = ((bext & ~hmask) << 1) | kk;
        tw_sh = SW'(HW) - r_stage;
        tw_full = kk << tw_sh;
        o_tw_idx = tw_full[HW-1:0];
        o_addr_b = addr_a | half;
        o_bin = r_bcnt;
        o_last = (r_bcnt == HALF_LAST);
        o_ready = (r_state == S_LOAD);
        unique case (r_state)
            S_LOAD: o_addr_a = r_cnt;
            S_BF_RD, S_BF_MUL, S_BF_WA, S_BF_WB: o_addr_a = addr_a;
            default: o_addr_a = bext;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_stage = r_stage;
        n_bcnt = r_bcnt;
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_cmd.ld_we = 1'b1;
                    n_cnt = r_cnt + IW'(1);
                    if (r_cnt == CNT_LAST) begin
                        n_cnt = '0;
                        n_stage = '0;
                        n_bcnt = '0;
                        n_state = S_BF_RD;
                    end
                end
            end
            S_BF_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_BF_MUL;
            end
            S_BF_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_BF_WA;
            end
            S_BF_WA: begin
                o_cmd.wr_sum = 1'b1;
                n_state = S_BF_WB;
            end
            S_BF_WB: begin
                o_cmd.wr_diff = 1'b1;
                n_bcnt = r_bcnt + HW'(1);
                n_state = S_BF_RD;
                if (r_bcnt == HALF_LAST) begin
                    n_bcnt = '0;
                    n_stage = r_stage + SW'(1);
                    if (r_stage == STG_LAST) begin
                        n_stage = '0;
                        o_cmd.pk_clr = 1'b1;
                        n_state = S_PK_RD;
                    end
                end
            end
            S_PK_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_PK_SQ;
            end
            S_PK_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = S_PK_ACC;
            end
            S_PK_ACC: begin
                o_cmd.pk_acc = 1'b1;
                n_bcnt = r_bcnt + HW'(1);
                n_state = S_PK_RD;
                if (r_bcnt == HALF_LAST) begin
                    n_bcnt = '0;
                    n_state = S_PK_GO;
                end
            end
            S_PK_GO: begin
                o_cmd.lg_start = 1'b1;
                o_cmd.lg_sel_pk = 1'b1;
                n_state = S_PK_LOG;
            end
            S_PK_LOG: begin
                if (i_stat.lg_done) begin
                    n_state = S_PK_DB;
                end
            end
            S_PK_DB: begin
                o_cmd.db_pk = 1'b1;
                n_state = S_LV_RD;
            end
            S_LV_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_LV_SQ;
            end
            S_LV_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = S_LV_ACC;
            end
            S_LV_ACC: begin
                o_cmd.pw_load = 1'b1;
                n_state = S_LV_GO;
            end
            S_LV_GO: begin
                o_cmd.lg_start = 1'b1;
                n_state = S_LV_LOG;
            end
            S_LV_LOG: begin
                if (i_stat.lg_done) begin
                    n_state = S_LV_DB;
                end
            end
            S_LV_DB: begin
                o_cmd.db_lv = 1'b1;
                n_state = S_LV_OUT;
            end
            S_LV_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_bcnt = r_bcnt + HW'(1);
                    n_state = S_LV_RD;
                    if (r_bcnt == HALF_LAST) begin
                        n_bcnt = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_stage <= '0;
            r_bcnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_stage <= n_stage;
            r_bcnt <= n_bcnt;
        end
    end

`ifndef SYNTH
    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while output register still full");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.lg_done |-> (r_state == S_PK_LOG || r_state == S_LV_LOG))
        else $error("log unit finished outside a wait state");
    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lg_start |=> (r_state == S_PK_LOG || r_state == S_LV_LOG))
        else $error("log unit started without waiting for it");
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LV_OUT && i_stat.out_free && r_bcnt == HALF_LAST)
        |=> (r_state == S_LOAD && r_cnt == '0))
        else $error("frame did not return to sample loading");
`endif
endmodule
`default_nettype wire

### design/windowed_fft_db_spectrum_unit.sv
// Takes one sample per cycle while loading; the frame's last sample starts processing.
// Processing runs N/2*log2(N) butterflies, each a read, multiply, sum write and difference write
// (one memory write port), then a peak search over the bins and the peak's dB, then for each bin
// its level (each waiting on the iterative log2 unit); an output stall holds the bin loop.
// Reset is synchronous, active low, and clears the controller, log2 control, peak and output valid.
`default_nettype none
module windowed_fft_db_spectrum_unit import wfds_pkg::*; #(
    parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [7:0]  i_sample,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [5:0]              o_bin_index,
    output logic signed [11:0]      o_level_db,
    output logic                    o_last_bin
);
    localparam int LOG2N = $clog2(FRAME_SIZE);

    t_cmd cmd;
    t_stat stat;
    logic [LOG2N-1:0] addr_a, addr_b;
    logic [LOG2N-2:0] tw_idx, bin;
    logic last;

    wfds_ctrl #(.FRAME_SIZE(FRAME_SIZE)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_cmd    (cmd),
        .i_stat   (stat),
        .o_addr_a (addr_a),
        .o_addr_b (addr_b),
        .o_tw_idx (tw_idx),
        .o_bin    (bin),
        .o_last   (last)
    );

    wfds_datapath #(.FRAME_SIZE(FRAME_SIZE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_addr_a    (addr_a),
        .i_addr_b    (addr_b),
        .i_tw_idx    (tw_idx),
        .i_bin       (bin),
        .i_last      (last),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_bin_index (o_bin_index),
        .o_level_db  (o_level_db),
        .o_last_bin  (o_last_bin)
    );
endmodule
`default_nettype wire

### tb/sv/testbench.sv
module testbench;
    import wfds_pkg::*;

    localparam int N = FRAME_SIZE_DEF;
    localparam int FRAME_IMPULSE = 0;
    localparam int FRAME_LOUD = 1;

    typedef struct {
        logic [5:0]         bin_index;
        logic signed [11:0] level_db;
        logic               last_bin;
    } bin_level_t;

    // Tracks the block's frame buffer and peak and holds the spectrum still owed.
    class spectrum_scoreboard;
        logic [63:0] buffer [N];
        int unsigned sample_count;
        longint unsigned peak_power;
        bin_level_t pending_bins [$];
        int errors;

        function new();
            sample_count = 0;
            peak_power = 0;
            errors = 0;
        endfunction

        function automatic longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function automatic longint turn_cos(longint unsigned p);
            longint unsigned quad, r, x, x2, term;
            longint c, s, v;
            p = p & 64'hFFFF;
            quad = p >> 14;
            r = p & 64'h3FFF;
            x = (r * 64'd3373259426 + 64'd16384) >> 15;
            x2 = (x * x) >> 30;
            c = longint'(1) <<< 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) c = c - longint'(term);
                else c = c + longint'(term);
            end
            s = longint'(x);
            term = x;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) s = s - longint'(term);
                else s = s + longint'(term);
            end
            if (c < 0) c = 0;
            if (s < 0) s = 0;
            case (quad)
                0: v = c;
                1: v = -s;
                2: v = -c;
                default: v = s;
            endcase
            return round_shift(v, 15);
        endfunction

        function automatic longint re_part(logic [63:0] w);
            return longint'($signed(w[31:0]));
        endfunction

        function automatic longint im_part(logic [63:0] w);
            return longint'($signed(w[63:32]));
        endfunction

        function automatic logic [63:0] join_parts(longint re, longint im);
            logic [63:0] w;
            w[31:0] = re[31:0];
            w[63:32] = im[31:0];
            return w;
        endfunction

        function automatic void transform();
            int half;
            longint unsigned ph;
            longint wr, wi, ar, ai, br, bi, tr, ti;
            for (int span = 2; span <= N; span = span * 2) begin
                half = span / 2;
                for (int j = 0; j + span <= N; j += span) begin
                    for (int k = 0; k < half; k++) begin
                        ph = (longint'(k) * 65536) / span;
                        wr = turn_cos(ph);
                        wi = turn_cos(ph + 16384);
                        ar = re_part(buffer[j + k]);
                        ai = im_part(buffer[j + k]);
                        br = re_part(buffer[j + k + half]);
                        bi = im_part(buffer[j + k + half]);
                        tr = round_shift(wr * br - wi * bi, 15);
                        ti = round_shift(wr * bi + wi * br, 15);
                        buffer[j + k] = join_parts(ar + tr, ai + ti);
                        buffer[j + k + half] = join_parts(ar - tr, ai - ti);
                    end
                end
            end
        endfunction

        function automatic longint unsigned bin_power(int i);
            longint re, im;
            longint unsigned p;
            re = re_part(buffer[i]);
            im = im_part(buffer[i]);
            if (re < 0) re = -re;
            if (im < 0) im = -im;
            p = longint'(re) * re + longint'(im) * im;
            if (p > 64'hFFFF_FFFF_FFFF) p = 64'hFFFF_FFFF_FFFF;
            return p;
        endfunction

        function automatic longint log2_q16(longint unsigned p);
            int e;
            longint unsigned m, frac;
            e = 63;
            frac = 0;
            while (e > 0 && p[e] == 1'b0) e--;
            m = (e >= 30) ? (p >> (e - 30)) : (p << (30 - e));
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return (longint'(e) <<< 16) | longint'(frac);
        endfunction

        function automatic longint fine_db(longint unsigned p);
            if (p == 0) return -(longint'(1920) <<< 32);
            return longint'(3156528) * (log2_q16(p) - longint'(20 * 65536));
        endfunction

        // Called once per accepted sample; the frame's last sample yields the spectrum.
        function automatic void note_sample(logic signed [7:0] smp);
            longint unsigned ph, p;
            longint w, x, pk, lv;
            int bits, idx;
            bin_level_t b;
            if (sample_count >= N) sample_count = 0;
            ph = (longint'(sample_count) * 131072 + (N - 1)) / (2 * (N - 1));
            w = 17695 - round_shift(longint'(15073) * turn_cos(ph), 15);
            x = round_shift(longint'(smp) * w, 5);
            bits = $clog2(N);
            idx = 0;
            for (int k = 0; k < bits; k++)
                if ((sample_count >> k) & 1) idx |= 1 << (bits - 1 - k);
            buffer[idx] = join_parts(x, 0);
            sample_count++;
            if (sample_count < N) return;
            sample_count = 0;
            transform();
            peak_power = 0;
            for (int i = 0; i < N / 2; i++) begin
                p = bin_power(i);
                if (p > peak_power) peak_power = p;
            end
            pk = fine_db(peak_power);
            for (int i = 0; i < N / 2; i++) begin
                p = bin_power(i);
                if (p < (64'd1 << 20)) p = 64'd1 << 20;
                lv = round_shift(fine_db(p) - pk, 32);
                if (lv < -2048) lv = -2048;
                if (lv > 2047) lv = 2047;
                b.bin_index = i[5:0];
                b.level_db = lv[11:0];
                b.last_bin = (i == N / 2 - 1);
                pending_bins.push_back(b);
            end
        endfunction

        function automatic void check_bin(logic [5:0] idx, logic signed [11:0] lvl,
                                          logic last);
            bin_level_t b;
            if (pending_bins.size() == 0) begin
                $error("unexpected result: bin_index %0d level_db %0d", idx, lvl);
                errors++;
                return;
            end
            b = pending_bins.pop_front();
            if (idx !== b.bin_index) begin
                $error("bin_index: expected %0d, actual %0d", b.bin_index, idx);
                errors++;
            end
            if (lvl !== b.level_db) begin
                $error("level_db: expected %0d, actual %0d", b.level_db, lvl);
                errors++;
            end
            if (last !== b.last_bin) begin
                $error("last_bin: expected %0d, actual %0d", b.last_bin, last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [7:0]  i_sample;
    logic               o_valid;
    logic               i_ready;
    logic [5:0]         o_bin_index;
    logic signed [11:0] o_level_db;
    logic               o_last_bin;

    spectrum_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    windowed_fft_db_spectrum_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sample(i_sample),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_bin_index(o_bin_index),
        .o_level_db(o_level_db),
        .o_last_bin(o_last_bin)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Drives one sample and returns on the falling edge after its transaction.
    task automatic send_sample(logic signed [7:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_sample = smp;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(smp);
        @(negedge i_clk);
    endtask

    task automatic wait_spectrum_drained();
        while (sb.pending_bins.size() != 0) @(negedge i_clk);
    endtask

    // Sends samples first .. first+count-1 of a frame of the given kind.
    task automatic send_part(int kind, int first, int count);
        logic signed [7:0] smp;
        for (int i = first; i < first + count; i++) begin
            case (kind)
                FRAME_IMPULSE: smp = (i == 0) ? 8'sd1 : 8'sd0;
                default: begin
                    // Full-scale extremes and small values, a Nyquist-rate square wave, then random samples.
                    case (i)
                        0: smp = -8'sd128;
                        1: smp = 8'sd127;
                        2: smp = 8'sd0;
                        3: smp = -8'sd1;
                        4: smp = 8'sd1;
                        default: begin
                            if (i < N / 2) smp = (i % 2 == 1) ? 8'sd127 : -8'sd128;
                            else smp = $signed(8'($urandom_range(255)));
                        end
                    endcase
                end
            endcase
            send_sample(smp);
        end
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready && i_rst_n)
                sb.check_bin(o_bin_index, o_level_db, o_last_bin);
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_part(FRAME_LOUD, 0, N / 2);
        send_idle_pct = 80;
        send_part(FRAME_LOUD, N / 2, N / 2);
        send_idle_pct = 0;
        recv_stall_pct = 80;
        i_valid = 1'b0;
        @(negedge i_clk);
        wait_spectrum_drained();
        send_idle_pct = 8;
        recv_stall_pct = 8;
        // A lone unit sample at the low window edge: peak below one, every bin floored.
        send_part(FRAME_IMPULSE, 0, N);
        i_valid = 1'b0;

        wait_spectrum_drained();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
